/* rtl/source_text_tokenizer_assert.svh */
// Assertion macros for the source text tokenizer checks.
// Included by the checker module; depends on nothing else.
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define STT_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed: same-cycle rule");

// Next-cycle implication, off during reset.
`define STT_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed: next-cycle rule");

// Next-cycle implication that also holds across reset.
`define STT_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tokenizer check failed: reset rule");

`endif

/* rtl/stt_pkg.sv */
// Shared types, character codes and classifier functions for the tokenizer.
// No dependencies; every other tokenizer file but the assertion header imports it.
`timescale 1ns / 1ps

package stt_pkg;

  localparam int CHAR_W      = 8;
  localparam int TEXT_W      = 64;
  localparam int TEXT_BYTES  = 16;
  localparam int LEN_W       = 5;
  localparam int POS_OUT_W   = 16;
  // Event queue depth; must be a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    TT_EOF    = 4'd0,
    TT_NUMBER = 4'd1,
    TT_PLUS   = 4'd2,
    TT_MINUS  = 4'd3,
    TT_MUL    = 4'd4,
    TT_DIV    = 4'd5,
    TT_LPAREN = 4'd6,
    TT_RPAREN = 4'd7,
    TT_ASSIGN = 4'd8,
    TT_SEMI   = 4'd9,
    TT_LBRACE = 4'd10,
    TT_RBRACE = 4'd11,
    TT_IDENT  = 4'd12,
    TT_ERROR  = 4'd13
  } token_type_t;

  typedef enum logic [2:0] {
    SM_IDLE,
    SM_NUMBER,
    SM_IDENT,
    SM_HASH,
    SM_LINE,
    SM_BLOCK,
    SM_BLOCK_HASH,
    SM_DRAIN
  } scan_mode_t;

  localparam logic [CHAR_W-1:0] CH_END        = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR         = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [CHAR_W-1:0] CH_HASH       = "#";
  localparam logic [CHAR_W-1:0] CH_PLUS       = "+";
  localparam logic [CHAR_W-1:0] CH_MINUS      = "-";
  localparam logic [CHAR_W-1:0] CH_STAR       = "*";
  localparam logic [CHAR_W-1:0] CH_SLASH      = "/";
  localparam logic [CHAR_W-1:0] CH_LPAREN     = "(";
  localparam logic [CHAR_W-1:0] CH_RPAREN     = ")";
  localparam logic [CHAR_W-1:0] CH_EQUAL      = "=";
  localparam logic [CHAR_W-1:0] CH_SEMI       = ";";
  localparam logic [CHAR_W-1:0] CH_LBRACE     = "{";
  localparam logic [CHAR_W-1:0] CH_RBRACE     = "}";
  localparam logic [CHAR_W-1:0] CH_DOT        = ".";
  localparam logic [CHAR_W-1:0] CH_UNDERSCORE = "_";
  localparam logic [CHAR_W-1:0] CH_ZERO       = "0";
  localparam logic [CHAR_W-1:0] CH_NINE       = "9";
  localparam logic [CHAR_W-1:0] CH_LOWER_A    = "a";
  localparam logic [CHAR_W-1:0] CH_LOWER_Z    = "z";
  localparam logic [CHAR_W-1:0] CH_UPPER_A    = "A";
  localparam logic [CHAR_W-1:0] CH_UPPER_Z    = "Z";

  // Results caused by one source byte: an optional closed token, then an
  // optional token (or eof) from the byte itself. Line is shared: the two
  // can only differ on a newline, which emits nothing of its own.
  typedef struct packed {
    logic                   has_flush;
    token_type_t            flush_type;
    logic [TEXT_W-1:0]      text_low;
    logic [TEXT_W-1:0]      text_high;
    logic [LEN_W-1:0]       flush_length;
    logic                   flush_trunc;
    logic [POS_OUT_W-1:0]   flush_column;
    logic                   has_own;
    token_type_t            own_type;
    logic [CHAR_W-1:0]      own_char;
    logic [POS_OUT_W-1:0]   own_column;
    logic [POS_OUT_W-1:0]   line;
  } tok_event_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic ident_start(input logic [CHAR_W-1:0] c);
    return is_alpha(c) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic ident_cont(input logic [CHAR_W-1:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE) || (c == CH_DOT);
  endfunction

  // TT_EOF means "not a one-character token".
  function automatic token_type_t single_type(input logic [CHAR_W-1:0] c);
    token_type_t t;
    unique case (c)
      CH_PLUS:   t = TT_PLUS;
      CH_MINUS:  t = TT_MINUS;
      CH_STAR:   t = TT_MUL;
      CH_SLASH:  t = TT_DIV;
      CH_LPAREN: t = TT_LPAREN;
      CH_RPAREN: t = TT_RPAREN;
      CH_EQUAL:  t = TT_ASSIGN;
      CH_SEMI:   t = TT_SEMI;
      CH_LBRACE: t = TT_LBRACE;
      CH_RBRACE: t = TT_RBRACE;
      default:   t = TT_EOF;
    endcase
    return t;
  endfunction

  function automatic logic [POS_OUT_W-1:0] fit_pos(input logic [31:0] v);
    return v[POS_OUT_W-1:0];
  endfunction

endpackage

/* rtl/stt_byte_if.sv */
// Source byte channel: valid/ready handshake carrying one byte per transfer.
// Depends on stt_pkg.
`timescale 1ns / 1ps

interface stt_byte_if;
  import stt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

/* rtl/stt_token_if.sv */
// Token channel: valid/ready handshake carrying one token per transfer.
// Depends on stt_pkg.
`timescale 1ns / 1ps

interface stt_token_if;
  import stt_pkg::*;

  logic                 valid;
  logic                 ready;
  token_type_t          token_type;
  logic [TEXT_W-1:0]    text_low;
  logic [TEXT_W-1:0]    text_high;
  logic [LEN_W-1:0]     text_length;
  logic                 truncated;
  logic [POS_OUT_W-1:0] line_number;
  logic [POS_OUT_W-1:0] column_number;
  logic                 last;

  modport source (output valid, output token_type, output text_low, output text_high,
                  output text_length, output truncated, output line_number,
                  output column_number, output last, input ready);
  modport sink   (input valid, input token_type, input text_low, input text_high,
                  input text_length, input truncated, input line_number,
                  input column_number, input last, output ready);
endinterface

/* rtl/stt_front.sv */
// Tokenizer front: takes source bytes, runs the scan state machine, tracks
// line/column and the token text, and builds one result event per byte.
// Depends on stt_pkg and stt_byte_if.
`timescale 1ns / 1ps

module stt_front #(
  parameter int MAX_TOKEN_CHARS = 16,
  parameter int POSITION_WIDTH  = 16
) (
  input  logic                clk,
  input  logic                rst,
  stt_byte_if.sink            src,
  output logic                push,
  output stt_pkg::tok_event_t evt,
  input  logic                full
);
  import stt_pkg::*;

  localparam int IDX_W = (MAX_TOKEN_CHARS > 1) ? $clog2(MAX_TOKEN_CHARS) : 1;
  localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};
  localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);
  localparam logic [LEN_W-1:0]          LEN_MAX = LEN_W'(MAX_TOKEN_CHARS);

  scan_mode_t mode, mode_next, eff_mode;

  logic [CHAR_W-1:0]         chars [MAX_TOKEN_CHARS];
  logic [LEN_W-1:0]          token_len;
  logic                      token_overflow;
  logic [POSITION_WIDTH-1:0] current_line;
  logic [POSITION_WIDTH-1:0] current_column;
  logic [POSITION_WIDTH-1:0] token_start_column;

  logic [POSITION_WIDTH-1:0] line_adv, col_adv;
  logic [TEXT_BYTES*CHAR_W-1:0] packed_text;
  logic [CHAR_W-1:0] c;
  logic take, is_end, is_nl, flush, begin_tok, append, room;
  token_type_t single;

  assign src.ready = !full;
  assign take      = src.valid && src.ready;
  assign c         = src.ch;
  assign is_end    = (c == CH_END);
  assign is_nl     = (c == CH_NEWLINE);
  assign single    = single_type(c);
  assign room      = (token_len < LEN_MAX);

  // A number or identifier closes on the first byte that cannot extend it.
  assign flush    = ((mode == SM_NUMBER) && !is_digit(c)) ||
                    ((mode == SM_IDENT) && !ident_cont(c));
  assign eff_mode = flush ? SM_IDLE : mode;

  always_comb begin
    if (is_nl) begin
      line_adv = (current_line == POS_MAX) ? current_line : current_line + POS_ONE;
      col_adv  = '0;
    end else begin
      line_adv = current_line;
      col_adv  = (current_column == POS_MAX) ? current_column : current_column + POS_ONE;
    end
  end

  always_comb begin
    packed_text = '0;
    for (int i = 0; i < MAX_TOKEN_CHARS; i++) begin
      packed_text[CHAR_W*i +: CHAR_W] = chars[i];
    end
  end

  // Next scan mode.
  always_comb begin
    mode_next = eff_mode;
    if (is_end) begin
      mode_next = SM_IDLE;
    end else begin
      unique case (eff_mode)
        SM_NUMBER, SM_IDENT, SM_DRAIN: mode_next = eff_mode;
        SM_HASH: begin
          if (c == CH_HASH) mode_next = SM_BLOCK;
          else if (is_nl)   mode_next = SM_IDLE;
          else              mode_next = SM_LINE;
        end
        SM_LINE:       mode_next = is_nl ? SM_IDLE : SM_LINE;
        SM_BLOCK:      mode_next = (c == CH_HASH) ? SM_BLOCK_HASH : SM_BLOCK;
        SM_BLOCK_HASH: mode_next = (c == CH_HASH) ? SM_IDLE : SM_BLOCK;
        SM_IDLE: begin
          priority if (c == CH_HASH)    mode_next = SM_HASH;
          else if (single != TT_EOF)    mode_next = SM_IDLE;
          else if (is_digit(c))         mode_next = SM_NUMBER;
          else if (ident_start(c))      mode_next = SM_IDENT;
          else if (!is_space(c))        mode_next = SM_DRAIN;
          else                          mode_next = SM_IDLE;
        end
        default: mode_next = SM_IDLE;
      endcase
    end
  end

  // Result event and token buffer controls.
  always_comb begin
    evt              = '0;
    begin_tok        = 1'b0;
    append           = 1'b0;
    evt.has_flush    = flush;
    evt.flush_type   = (mode == SM_NUMBER) ? TT_NUMBER : TT_IDENT;
    evt.text_low     = packed_text[TEXT_W-1:0];
    evt.text_high    = packed_text[2*TEXT_W-1:TEXT_W];
    evt.flush_length = token_len;
    evt.flush_trunc  = token_overflow;
    evt.flush_column = fit_pos(32'(token_start_column));
    evt.line         = fit_pos(32'(current_line));
    evt.own_type     = TT_EOF;
    evt.own_char     = c;
    evt.own_column   = fit_pos(32'(col_adv));
    if (is_end) begin
      evt.has_own    = 1'b1;
      evt.own_char   = '0;
      evt.own_column = fit_pos(32'(current_column));
    end else if (eff_mode == SM_IDLE) begin
      priority if (c == CH_HASH) begin
        evt.has_own = 1'b0;
      end else if (single != TT_EOF) begin
        evt.has_own  = 1'b1;
        evt.own_type = single;
      end else if (is_digit(c) || ident_start(c)) begin
        begin_tok = 1'b1;
      end else if (!is_space(c)) begin
        evt.has_own  = 1'b1;
        evt.own_type = TT_ERROR;
      end else begin
        evt.has_own = 1'b0;
      end
    end else if ((eff_mode == SM_NUMBER) || (eff_mode == SM_IDENT)) begin
      append = 1'b1;
    end
  end

  assign push = take && (evt.has_flush || evt.has_own);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= SM_IDLE;
    end else if (take) begin
      mode <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_len          <= '0;
      token_overflow     <= 1'b0;
      current_line       <= POS_ONE;
      current_column     <= '0;
      token_start_column <= '0;
    end else if (take) begin
      if (is_end) begin
        token_len          <= '0;
        token_overflow     <= 1'b0;
        current_line       <= POS_ONE;
        current_column     <= '0;
        token_start_column <= '0;
      end else begin
        current_line   <= line_adv;
        current_column <= col_adv;
        if (begin_tok) begin
          token_len          <= LEN_W'(1);
          token_overflow     <= 1'b0;
          token_start_column <= col_adv;
        end else if (append) begin
          if (room) token_len <= token_len + LEN_W'(1);
          else      token_overflow <= 1'b1;
        end
      end
    end
  end

  // Clear the buffer on a new token so bytes past the length read as zero.
  always_ff @(posedge clk) begin
    if (take && begin_tok) begin
      for (int i = 0; i < MAX_TOKEN_CHARS; i++) begin
        chars[i] <= (i == 0) ? c : '0;
      end
    end else if (take && append && room) begin
      chars[token_len[IDX_W-1:0]] <= c;
    end
  end

endmodule

/* rtl/stt_queue.sv */
// Small event queue between the tokenizer front and back.
// Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  stt_pkg::tok_event_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output stt_pkg::tok_event_t head_data
);
  import stt_pkg::*;

  localparam logic [QPTR_W:0] DEPTH_COUNT = QUEUE_DEPTH[QPTR_W:0];

  tok_event_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == DEPTH_COUNT);
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/stt_back.sv */
// Tokenizer back: unpacks each queued event into one or two tokens and
// holds them in the output register until transferred.
// Depends on stt_pkg and stt_token_if.
`timescale 1ns / 1ps

module stt_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  stt_pkg::tok_event_t head_data,
  output logic                pop,
  stt_token_if.source         tok
);
  import stt_pkg::*;

  logic flush_done;
  logic load, send_flush;

  assign load       = head_valid && (!tok.valid || tok.ready);
  assign send_flush = head_data.has_flush && !flush_done;
  // Keep the event when its closed token goes out and its own token follows.
  assign pop        = load && !(send_flush && head_data.has_own);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid  <= 1'b0;
      flush_done <= 1'b0;
    end else begin
      if (load)           tok.valid <= 1'b1;
      else if (tok.ready) tok.valid <= 1'b0;
      if (load) flush_done <= send_flush && head_data.has_own;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok.line_number <= head_data.line;
      if (send_flush) begin
        tok.token_type    <= head_data.flush_type;
        tok.text_low      <= head_data.text_low;
        tok.text_high     <= head_data.text_high;
        tok.text_length   <= head_data.flush_length;
        tok.truncated     <= head_data.flush_trunc;
        tok.column_number <= head_data.flush_column;
        tok.last          <= !head_data.has_own;
      end else begin
        tok.token_type    <= head_data.own_type;
        tok.text_low      <= TEXT_W'(head_data.own_char);
        tok.text_high     <= '0;
        tok.text_length   <= (head_data.own_type == TT_EOF) ? '0 : LEN_W'(1);
        tok.truncated     <= 1'b0;
        tok.column_number <= head_data.own_column;
        tok.last          <= 1'b1;
      end
    end
  end

endmodule

/* rtl/source_text_tokenizer.sv */
// Source text tokenizer top level: front scanner, event queue, token output.
// Depends on stt_pkg, stt_byte_if, stt_token_if, stt_front, stt_queue, stt_back.
//
// Takes one source byte per cycle on src (byte 0 ends the text and returns the
// scanner to its reset state) and emits tokens on tok with the line and 1-based
// column of their start and up to MAX_TOKEN_CHARS characters of text. A byte
// is accepted in the cycle it is offered unless the four-entry event queue
// is full; its tokens pass through the event queue and the output register.
// A byte that closes a number or identifier and also yields a token of its
// own produces two results, and the output register delivers one result per
// cycle, so the sustained rate is one byte per cycle as long as the output is
// taken every cycle and such two-result bytes are spaced out; otherwise it is
// set by the output side at most one token per cycle.
`timescale 1ns / 1ps

module source_text_tokenizer #(
  parameter int MAX_TOKEN_CHARS = 16,
  parameter int POSITION_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst,
  stt_byte_if.sink    src,
  stt_token_if.source tok
);
  import stt_pkg::*;

  tok_event_t push_data, head_data;
  logic       push, full, pop, head_valid;

  stt_front #(
    .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS),
    .POSITION_WIDTH  (POSITION_WIDTH)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .src  (src),
    .push (push),
    .evt  (push_data),
    .full (full)
  );

  stt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  stt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .tok        (tok)
  );

endmodule

/* rtl/stt_checker.sv */
// Port-level checks on the tokenizer output, attached to the top by bind.
// Depends on stt_pkg and source_text_tokenizer_assert.svh.
`timescale 1ns / 1ps
`include "source_text_tokenizer_assert.svh"

module stt_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  tok_valid,
  input logic                  tok_ready,
  input stt_pkg::token_type_t  tok_type,
  input logic [stt_pkg::TEXT_W-1:0] tok_text_low,
  input logic [stt_pkg::LEN_W-1:0]  tok_length,
  input logic                  tok_truncated,
  input logic                  tok_last
);
  import stt_pkg::*;

  logic is_eof, is_text, is_single, eof_ok, single_ok;
  logic [4+TEXT_W:0] out_word;

  assign is_eof    = (tok_type == TT_EOF);
  assign is_text   = (tok_type == TT_NUMBER) || (tok_type == TT_IDENT);
  assign is_single = !is_eof && !is_text;
  assign eof_ok    = tok_last && (tok_length == '0) && !tok_truncated;
  assign single_ok = tok_last && (tok_length == LEN_W'(1)) && !tok_truncated;
  assign out_word  = {tok_type, tok_text_low, tok_last};

  // Reset empties the output register.
  `STT_ASSERT_NEXT_ALWAYS(a_reset_clears_output, clk, rst, !tok_valid)

  // Eof carries no text and ends the results of its byte.
  `STT_ASSERT_IMPLY(a_eof_shape, clk, rst, tok_valid && is_eof, eof_ok)

  // One-character and error tokens are final and one character long.
  `STT_ASSERT_IMPLY(a_single_shape, clk, rst, tok_valid && is_single, single_ok)

  // Only a closed number or identifier can be followed by another result.
  `STT_ASSERT_IMPLY(a_nonlast_is_flush, clk, rst, tok_valid && !tok_last, is_text)

  // A stalled token holds.
  `STT_ASSERT_NEXT(a_stall_hold, clk, rst, tok_valid && !tok_ready, tok_valid && $stable(out_word))

endmodule

bind source_text_tokenizer stt_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .tok_valid     (tok.valid),
  .tok_ready     (tok.ready),
  .tok_type      (tok.token_type),
  .tok_text_low  (tok.text_low),
  .tok_length    (tok.text_length),
  .tok_truncated (tok.truncated),
  .tok_last      (tok.last)
);
